[sv/pwi_pkg.sv]
// pwi_pkg: shared widths, control-word types and the microcode program of the
// PID block with a sliding-window integral. No dependencies.
package pwi_pkg;

   localparam int WINDOW_DEPTH = 16;
   localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

   localparam int REQ_W    = 48;   // sample_time + position
   localparam int RSP_W    = 32;   // adjustment
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 16;

   localparam int ERR_W   = 17;
   localparam int DERR_W  = 18;
   localparam int AREA_W  = 34;
   localparam int SUM_W   = 40;
   localparam int HALF_W  = 20;    // sum split for the multiplier
   localparam int DIV_BITS = 25;   // |derr| << 8 fits in 25 bits
   localparam int DER_W   = 26;
   localparam int MA_W    = 17;
   localparam int MB_W    = 27;
   localparam int PROD_W  = 44;
   localparam int ACC_W   = 58;
   localparam int CNT_W   = 5;
   localparam int PC_W    = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_SETPOINT = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P   = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I   = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D   = 8'd3;

   typedef logic [PC_W-1:0] pc_type;

   typedef enum logic [2:0] {
      MUL_NONE, MUL_AREA, MUL_P, MUL_ILO, MUL_IHI, MUL_D
   } mul_sel_type;

   typedef enum logic [2:0] {
      ACC_HOLD, ACC_CLR, ACC_ADD, ACC_ADD_SH20, ACC_ADD_ASR8
   } acc_op_type;

   typedef enum logic [1:0] {
      DIV_HOLD, DIV_INIT, DIV_STEP, DIV_FIX
   } div_op_type;

   typedef enum logic [1:0] {
      ACT_NONE, ACT_PREP, ACT_AREA, ACT_OUT
   } act_type;

   typedef enum logic [2:0] {
      JMP_NEXT, JMP_WAIT_IN, JMP_LOOP, JMP_WAIT_OUT, JMP_GOTO
   } jmp_type;

   typedef struct packed {
      logic        take_in;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      div_op_type  div_op;
      act_type     act;
      jmp_type     jmp;
      pc_type      target;
   } ctrl_type;

   typedef struct packed {
      logic in_fire;
      logic div_more;
      logic out_busy;
   } stat_type;

   localparam pc_type PC_WAIT     = 4'd0;
   localparam pc_type PC_PREP     = 4'd1;
   localparam pc_type PC_AREA_MUL = 4'd2;
   localparam pc_type PC_AREA_ACC = 4'd3;
   localparam pc_type PC_I_LO     = 4'd4;
   localparam pc_type PC_I_HI     = 4'd5;
   localparam pc_type PC_I_ACC    = 4'd6;
   localparam pc_type PC_DIV_LOOP = 4'd7;
   localparam pc_type PC_DIV_FIX  = 4'd8;
   localparam pc_type PC_D_MUL    = 4'd9;
   localparam pc_type PC_D_ACC    = 4'd10;
   localparam pc_type PC_OUT      = 4'd11;

   localparam ctrl_type CTRL_NOP = '{take_in: 1'b0, mul_sel: MUL_NONE, acc_op: ACC_HOLD,
                                     div_op: DIV_HOLD, act: ACT_NONE, jmp: JMP_NEXT,
                                     target: PC_WAIT};

   // Microcode program. Multiplies issue in one step and are consumed in the next.
   function automatic ctrl_type ucode_rom(input pc_type pc);
      ctrl_type w;
      w = CTRL_NOP;
      case (pc)
         PC_WAIT: begin
            w.take_in = 1'b1;
            w.jmp     = JMP_WAIT_IN;
         end
         PC_PREP: begin
            w.act = ACT_PREP;
         end
         PC_AREA_MUL: begin
            w.mul_sel = MUL_AREA;
            w.acc_op  = ACC_CLR;
            w.div_op  = DIV_INIT;
         end
         PC_AREA_ACC: begin
            w.act     = ACT_AREA;
            w.mul_sel = MUL_P;
            w.div_op  = DIV_STEP;
         end
         PC_I_LO: begin
            w.acc_op  = ACC_ADD;
            w.mul_sel = MUL_ILO;
            w.div_op  = DIV_STEP;
         end
         PC_I_HI: begin
            w.acc_op  = ACC_ADD;
            w.mul_sel = MUL_IHI;
            w.div_op  = DIV_STEP;
         end
         PC_I_ACC: begin
            w.acc_op = ACC_ADD_SH20;
            w.div_op = DIV_STEP;
         end
         PC_DIV_LOOP: begin
            w.div_op = DIV_STEP;
            w.jmp    = JMP_LOOP;
            w.target = PC_DIV_LOOP;
         end
         PC_DIV_FIX: begin
            w.div_op = DIV_FIX;
         end
         PC_D_MUL: begin
            w.mul_sel = MUL_D;
         end
         PC_D_ACC: begin
            w.acc_op = ACC_ADD_ASR8;
         end
         PC_OUT: begin
            w.act    = ACT_OUT;
            w.jmp    = JMP_WAIT_OUT;
            w.target = PC_WAIT;
         end
         default: begin
            w.jmp    = JMP_GOTO;
            w.target = PC_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

[sv/pwi_seq.sv]
// pwi_seq: microcode sequencer, step counter plus program ROM with jumps.
// Depends on pwi_pkg.
module pwi_seq import pwi_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output ctrl_type ctrl
);

   pc_type pc_ff, pc_in;

   assign ctrl = ucode_rom(pc_ff);

   always_comb begin
      case (ctrl.jmp)
         JMP_NEXT:     pc_in = pc_ff + 1'b1;
         JMP_WAIT_IN:  pc_in = stat.in_fire ? pc_ff + 1'b1 : pc_ff;
         JMP_LOOP:     pc_in = stat.div_more ? ctrl.target : pc_ff + 1'b1;
         JMP_WAIT_OUT: pc_in = stat.out_busy ? pc_ff : ctrl.target;
         JMP_GOTO:     pc_in = ctrl.target;
         default:      pc_in = PC_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

[sv/pid_windowed_integral.sv]
// PID controller with a sliding-window integral: one result per input sample.
// Each sample runs through the 25-step restoring divider for the derivative and
// 5 multiplies on one shared multiplier; the next sample is taken only once the
// sequencer has passed its result to the output step.
// The output register lets the next sample transfer while a result waits.
// Reset (synchronous, active high) clears gains, setpoint, sum, history, window.
// Depends on pwi_pkg and pwi_seq.
module pid_windowed_integral import pwi_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [REQ_W-1:0]     req_tdata,   // [31:0] sample_time, [47:32] position
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata,   // [31:0] adjustment
   output logic [1:0]           rsp_tuser,   // [0] zero_step, [1] clipped
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   // ---------------- sequencer ----------------
   ctrl_type ctrl;
   stat_type stat;

   pwi_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   // ---------------- configuration ----------------
   logic signed [15:0] setpoint_ff, gain_p_ff, gain_i_ff, gain_d_ff;
   logic               csr_fire;
   logic               gain_write;

   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid & csr_ready;
   assign gain_write = csr_fire && (csr_index == CSR_GAIN_P || csr_index == CSR_GAIN_I
                                    || csr_index == CSR_GAIN_D);

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff <= '0;
         gain_p_ff   <= '0;
         gain_i_ff   <= '0;
         gain_d_ff   <= '0;
      end else if (csr_fire) begin
         case (csr_index)
            CSR_SETPOINT: setpoint_ff <= csr_data;
            CSR_GAIN_P:   gain_p_ff   <= csr_data;
            CSR_GAIN_I:   gain_i_ff   <= csr_data;
            CSR_GAIN_D:   gain_d_ff   <= csr_data;
            default: ;   // unknown index: ignored
         endcase
      end
   end

   // ---------------- input capture ----------------
   logic               in_fire;
   logic [31:0]        time_ff;
   logic signed [15:0] pos_ff;

   assign req_tready = ctrl.take_in;
   assign in_fire    = req_tvalid & req_tready;

   always_ff @(posedge clock) begin
      if (in_fire) begin
         time_ff <= req_tdata[31:0];
         pos_ff  <= req_tdata[47:32];
      end
   end

   // ---------------- error, time step, error change ----------------
   logic [31:0]              last_time_ff;
   logic signed [ERR_W-1:0]  last_err_ff;
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic signed [DERR_W-1:0] derr_ff, derr_in;
   logic [15:0]              step_ff, step_in;
   logic [31:0]              diff;
   logic                     zero_ff;

   assign err_in  = {pos_ff[15], pos_ff} - {setpoint_ff[15], setpoint_ff};
   assign derr_in = {err_in[ERR_W-1], err_in} - {last_err_ff[ERR_W-1], last_err_ff};
   assign diff    = time_ff - last_time_ff;
   // wrapped difference, saturated to 16 bits
   assign step_in = (|diff[31:16]) ? 16'hFFFF : diff[15:0];

   always_ff @(posedge clock) begin
      if (ctrl.act == ACT_PREP) begin
         err_ff  <= err_in;
         derr_ff <= derr_in;
         step_ff <= step_in;
         zero_ff <= (diff == 32'd0);
      end
   end

   // ---------------- shared multiplier ----------------
   logic signed [MA_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [PROD_W-1:0] prod_ff;
   logic [SUM_W-1:0]         sum_ff;
   logic signed [DER_W-1:0]  deriv_ff;

   always_comb begin
      case (ctrl.mul_sel)
         MUL_AREA: begin
            mul_a = err_ff;
            mul_b = {{(MB_W-16){1'b0}}, step_ff};
         end
         MUL_P: begin
            mul_a = {gain_p_ff[15], gain_p_ff};
            mul_b = {{(MB_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
         end
         MUL_ILO: begin
            // low half of the sum, unsigned
            mul_a = {gain_i_ff[15], gain_i_ff};
            mul_b = {{(MB_W-HALF_W){1'b0}}, sum_ff[HALF_W-1:0]};
         end
         MUL_IHI: begin
            mul_a = {gain_i_ff[15], gain_i_ff};
            mul_b = {{(MB_W-HALF_W){sum_ff[SUM_W-1]}}, sum_ff[SUM_W-1:HALF_W]};
         end
         MUL_D: begin
            mul_a = {gain_d_ff[15], gain_d_ff};
            mul_b = {deriv_ff[DER_W-1], deriv_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // ---------------- accumulator ----------------
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] prod_ext;

   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_ff @(posedge clock) begin
      case (ctrl.acc_op)
         ACC_CLR:      acc_ff <= '0;
         ACC_ADD:      acc_ff <= acc_ff + prod_ext;
         ACC_ADD_SH20: acc_ff <= acc_ff + (prod_ext <<< HALF_W);
         ACC_ADD_ASR8: acc_ff <= acc_ff + (prod_ext >>> 8);   // floor of the Q.8 product
         default:      acc_ff <= acc_ff;
      endcase
   end

   // ---------------- window memory and integral sum ----------------
   logic [AREA_W-1:0]       area_mem [WINDOW_DEPTH];
   logic [AREA_W-1:0]       old_rd_ff;
   logic [WINDOW_DEPTH-1:0] valid_ff;
   logic [PTR_W-1:0]        ptr_ff;
   logic [AREA_W-1:0]       area;
   logic [AREA_W-1:0]       oldest;
   logic                    area_wr;

   assign area_wr = (ctrl.act == ACT_AREA);
   assign area    = prod_ff[AREA_W-1:0];
   // an entry never written reads as zero
   assign oldest  = valid_ff[ptr_ff] ? old_rd_ff : '0;

   always_ff @(posedge clock) begin
      old_rd_ff <= area_mem[ptr_ff];
      if (area_wr) begin
         area_mem[ptr_ff] <= area;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         ptr_ff       <= '0;
         sum_ff       <= '0;
         last_time_ff <= '0;
         last_err_ff  <= '0;
      end else begin
         if (gain_write) begin
            sum_ff <= '0;
         end else if (area_wr) begin
            sum_ff <= sum_ff + {{(SUM_W-AREA_W){area[AREA_W-1]}}, area}
                             - {{(SUM_W-AREA_W){oldest[AREA_W-1]}}, oldest};
         end
         if (area_wr) begin
            valid_ff[ptr_ff] <= 1'b1;
            ptr_ff           <= (ptr_ff == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
            last_time_ff     <= time_ff;
            last_err_ff      <= err_ff;
         end
      end
   end

   // ---------------- restoring divider: (|derr| << 8) / step ----------------
   logic [DIV_BITS-1:0] dq_ff;      // dividend shifts out, quotient shifts in
   logic [15:0]         rem_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                neg_ff;
   logic [DERR_W-1:0]   derr_mag;
   logic [16:0]         trial;
   logic                qbit;

   assign derr_mag = derr_ff[DERR_W-1] ? DERR_W'(-derr_ff) : DERR_W'(derr_ff);
   assign trial    = {rem_ff, dq_ff[DIV_BITS-1]};
   assign qbit     = (trial >= {1'b0, step_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         case (ctrl.div_op)
            DIV_INIT: cnt_ff <= CNT_W'(DIV_BITS);
            DIV_STEP: cnt_ff <= cnt_ff - 1'b1;
            default:  cnt_ff <= cnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (ctrl.div_op)
         DIV_INIT: begin
            dq_ff  <= {derr_mag[DIV_BITS-9:0], 8'd0};
            rem_ff <= '0;
            neg_ff <= derr_ff[DERR_W-1];
         end
         DIV_STEP: begin
            dq_ff  <= {dq_ff[DIV_BITS-2:0], qbit};
            rem_ff <= qbit ? 16'(trial - {1'b0, step_ff}) : trial[15:0];
         end
         DIV_FIX: begin
            // truncation toward zero; a zero step forces the derivative to 0
            if (zero_ff) begin
               deriv_ff <= '0;
            end else if (neg_ff) begin
               deriv_ff <= -$signed({1'b0, dq_ff});
            end else begin
               deriv_ff <= $signed({1'b0, dq_ff});
            end
         end
         default: ;
      endcase
   end

   // ---------------- saturation and output register ----------------
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_adj_ff, sat_val;
   logic               rsp_zero_ff, rsp_clip_ff, sat_clip;
   logic               out_busy, out_load;

   always_comb begin
      if (!acc_ff[ACC_W-1] && (|acc_ff[ACC_W-2:RSP_W-1])) begin
         sat_val  = 32'h7FFF_FFFF;
         sat_clip = 1'b1;
      end else if (acc_ff[ACC_W-1] && !(&acc_ff[ACC_W-2:RSP_W-1])) begin
         sat_val  = 32'h8000_0000;
         sat_clip = 1'b1;
      end else begin
         sat_val  = acc_ff[RSP_W-1:0];
         sat_clip = 1'b0;
      end
   end

   assign out_busy     = rsp_valid_ff & ~rsp_tready;
   assign out_load     = (ctrl.act == ACT_OUT) & ~out_busy;
   assign rsp_valid_in = out_load | out_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_adj_ff  <= sat_val;
         rsp_zero_ff <= zero_ff;
         rsp_clip_ff <= sat_clip;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_adj_ff;
   assign rsp_tuser  = {rsp_clip_ff, rsp_zero_ff};

   // ---------------- sequencer status ----------------
   assign stat.in_fire  = in_fire;
   assign stat.div_more = (cnt_ff > CNT_W'(1));
   assign stat.out_busy = out_busy;

   // ---------------- assertions ----------------
   a_zero_deriv: assert property (@(posedge clock) disable iff (reset)
      (ctrl.div_op == DIV_FIX && zero_ff) |=> (deriv_ff == '0))
      else $error("zero step left a nonzero derivative");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (ctrl.div_op == DIV_FIX && !zero_ff) |-> (rem_ff < step_ff))
      else $error("divider remainder not below the step");

   a_clip_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_clip_ff) |-> (rsp_adj_ff == 32'h7FFF_FFFF
                                         || rsp_adj_ff == 32'h8000_0000))
      else $error("clipped result not at a rail");

   a_load_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.act == ACT_OUT))
      else $error("result appeared outside the output step");

endmodule
